// File: hw/rtl/c2d_pkg.sv
// Shared types, widths and register codes for the 3x3 zero-padded convolution core.
// No dependencies; every other file in hw/rtl except c2d_ram imports this package.
package c2d_pkg;

	localparam int MAX_WIDTH      = 1024;
	localparam int KERNEL_SIZE    = 3;
	localparam int PIXEL_BITS     = 8;
	localparam int COEF_BITS      = 8;

	localparam int COL_BITS       = $clog2(MAX_WIDTH);
	localparam int WIDTH_BITS     = 11;
	localparam int ROW_BITS       = 16;
	localparam int SHIFT_BITS     = 4;
	localparam int KROW_BITS      = KERNEL_SIZE * COEF_BITS;
	localparam int OUT_BITS       = 20;

	// column arithmetic wide enough for position + 2 against the clamped width
	localparam int COLX_BITS      = ((COL_BITS > WIDTH_BITS) ? COL_BITS : WIDTH_BITS) + 2;
	localparam int ROWX_BITS      = ROW_BITS + 2;

	localparam int PROD_BITS      = PIXEL_BITS + COEF_BITS + 1;
	localparam int SUM_BITS       = PROD_BITS + $clog2(KERNEL_SIZE * KERNEL_SIZE);
	localparam int ENTRY_BITS     = 2 * PIXEL_BITS;

	localparam int QUEUE_DEPTH    = 4;
	localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = KROW_BITS;

	localparam logic [KROW_BITS-1:0]  KROW_TOP_RST = '0;
	localparam logic [KROW_BITS-1:0]  KROW_MID_RST = KROW_BITS'(256);
	localparam logic [KROW_BITS-1:0]  KROW_BOT_RST = '0;
	localparam logic [WIDTH_BITS-1:0] WIDTH_RST    = WIDTH_BITS'(1024);
	localparam logic [ROW_BITS-1:0]   HEIGHT_RST   = ROW_BITS'(1024);
	localparam logic [SHIFT_BITS-1:0] SHIFT_RST    = '0;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_KERNEL_TOP   = 3'd0,
		REG_KERNEL_MID   = 3'd1,
		REG_KERNEL_BOT   = 3'd2,
		REG_IMAGE_WIDTH  = 3'd3,
		REG_IMAGE_HEIGHT = 3'd4,
		REG_RESULT_SHIFT = 3'd5
	} reg_index_t;

	typedef enum logic {
		KIND_PIXEL = 1'b0,
		KIND_DRAIN = 1'b1
	} kind_t;

	// element 0 is the row two above, 1 the row above, 2 the current row
	typedef logic [KERNEL_SIZE-1:0][PIXEL_BITS-1:0] column_t;

	// one classified item, handed from the front to the back
	typedef struct packed {
		column_t                col;
		column_t                spec;
		logic                   gate;
		logic                   row_start;
		logic                   frame_last;
		logic                   h1_load;
		logic [KERNEL_SIZE-1:0] rmask;
		logic [KERNEL_SIZE-1:0] cmask;
	} col_word_t;

	typedef struct packed {
		logic [WIDTH_BITS-1:0] width;
		logic [ROW_BITS-1:0]   height;
		logic                  restart;
	} geom_t;

	// krows[0] is the top kernel row
	typedef struct packed {
		logic [KERNEL_SIZE-1:0][KROW_BITS-1:0] krows;
		logic [SHIFT_BITS-1:0]                 shift;
		logic                                  restart;
	} arith_cfg_t;

endpackage

// File: hw/rtl/c2d_stream_if.sv
// Stream interfaces for the pixel input and result output channels.
// Depends on c2d_pkg for payload widths.
interface c2d_in_if import c2d_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  kind;
	logic [PIXEL_BITS-1:0] pixel;

	modport source (output valid, output kind, output pixel, input ready);
	modport sink   (input valid, input kind, input pixel, output ready);
endinterface

interface c2d_out_if import c2d_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] out_pixel;
	logic                       frame_last;

	modport source (output valid, output out_pixel, output frame_last, input ready);
	modport sink   (input valid, input out_pixel, input frame_last, output ready);
endinterface

// File: hw/rtl/conv2d_same_zero_pad_core.sv
// Top level of the 3x3 same-size convolution core with zero padding.
// Depends on c2d_pkg, c2d_stream_if, c2d_front, c2d_queue, c2d_back (and c2d_ram below).
//
//  channel   dir  handshake       word
//  pixels    in   valid/ready     kind, pixel[7:0]
//  results   out  valid/ready     out_pixel[19:0] signed, frame_last
//  cfg       in   cfg_write only  cfg_index[2:0], cfg_data[23:0]
//
// One word per clock while the column queue has room; the single write port of the
// line RAM, used in the cycle after each pixel, sets that figure. A result passes
// the front stage register and the column queue, then the back product, row-sum
// and output registers. Reset clears counters, window and handshake state at once;
// the line RAM needs no clearing pass. A stalled output holds the back pipeline;
// the front keeps accepting until the four-entry column queue fills.
module conv2d_same_zero_pad_core import c2d_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	c2d_in_if.sink                    pixels,
	c2d_out_if.source                 results
);
	logic [KERNEL_SIZE-1:0][KROW_BITS-1:0] krows_q;
	logic [WIDTH_BITS-1:0]                 width_q;
	logic [ROW_BITS-1:0]                   height_q;
	logic [SHIFT_BITS-1:0]                 shift_q;
	reg_index_t                            idx;
	logic                                  size_write;

	geom_t                                 geom;
	arith_cfg_t                            acfg;
	logic                                  push, pop;
	col_word_t                             push_word, head;
	logic [QCNT_BITS-1:0]                  queue_count;

	assign idx        = reg_index_t'(cfg_index);
	// a size write restarts the frame in the same edge that takes the value
	assign size_write = cfg_write && ((idx == REG_IMAGE_WIDTH) || (idx == REG_IMAGE_HEIGHT));

	// register file; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			krows_q[0] <= KROW_TOP_RST;
			krows_q[1] <= KROW_MID_RST;
			krows_q[2] <= KROW_BOT_RST;
			width_q    <= WIDTH_RST;
			height_q   <= HEIGHT_RST;
			shift_q    <= SHIFT_RST;
		end else if (cfg_write) begin
			unique case (idx)
				REG_KERNEL_TOP:   krows_q[0] <= cfg_data[KROW_BITS-1:0];
				REG_KERNEL_MID:   krows_q[1] <= cfg_data[KROW_BITS-1:0];
				REG_KERNEL_BOT:   krows_q[2] <= cfg_data[KROW_BITS-1:0];
				REG_IMAGE_WIDTH:  width_q    <= cfg_data[WIDTH_BITS-1:0];
				REG_IMAGE_HEIGHT: height_q   <= cfg_data[ROW_BITS-1:0];
				REG_RESULT_SHIFT: shift_q    <= cfg_data[SHIFT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		geom.width    = width_q;
		geom.height   = height_q;
		geom.restart  = size_write;
		acfg.krows    = krows_q;
		acfg.shift    = shift_q;
		acfg.restart  = size_write;
	end

	// front: classify each word, track positions, keep the two earlier rows
	c2d_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixels      (pixels),
		.geom        (geom),
		.queue_count (queue_count),
		.push        (push),
		.push_word   (push_word)
	);

	// queue: lets the front run on while the output side stalls
	c2d_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.head      (head),
		.count     (queue_count)
	);

	// back: window, multiply, sum, shift, output register
	c2d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.acfg        (acfg),
		.head        (head),
		.queue_count (queue_count),
		.pop         (pop),
		.results     (results)
	);
endmodule

// File: hw/rtl/c2d_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; read returns old data on a same-address write.
module c2d_ram #(
	parameter  int WIDTH = 16,
	parameter  int DEPTH = 1024,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: hw/rtl/c2d_front.sv
// Front end: accepts words, keeps position counters, reads and updates the line RAM.
// Depends on c2d_pkg, c2d_stream_if and c2d_ram; feeds c2d_queue.
module c2d_front import c2d_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	c2d_in_if.sink               pixels,
	input  geom_t                geom,
	input  logic [QCNT_BITS-1:0] queue_count,
	output logic                 push,
	output col_word_t            push_word
);
	logic [COLX_BITS-1:0]   eff_w_x;
	logic [ROW_BITS-1:0]    eff_h;
	logic [COL_BITS-1:0]    in_col_q, out_col_q;
	logic [ROW_BITS-1:0]    in_row_q, out_row_q;

	logic                   accept, is_drain, take_pix, take_drain, take;
	logic [COLX_BITS-1:0]   in_col_inc, out_col_inc, vic_x;
	logic [ROWX_BITS-1:0]   out_row_x, eff_h_x;
	logic [COL_BITS-1:0]    rd_addr;
	logic                   gate, row_start, h1_load, frame_last;
	logic [KERNEL_SIZE-1:0] rmask, cmask;

	logic                   valid_s1, pix_s1, gate_s1, row_start_s1;
	logic                   frame_last_s1, h1_load_s1, byp_s1;
	logic [KERNEL_SIZE-1:0] rmask_s1, cmask_s1;
	logic [COL_BITS-1:0]    addr_s1;
	logic [PIXEL_BITS-1:0]  pixel_s1;
	logic [ENTRY_BITS-1:0]  byp_data_s1, ram_rdata, entry, wr_data, shadow_q;
	logic                   wr_en;

	// clamp the geometry: zero acts as one, width tops out at the line length
	always_comb begin
		if (geom.width == '0) begin
			eff_w_x = COLX_BITS'(1);
		end else if (COLX_BITS'(geom.width) > COLX_BITS'(MAX_WIDTH)) begin
			eff_w_x = COLX_BITS'(MAX_WIDTH);
		end else begin
			eff_w_x = COLX_BITS'(geom.width);
		end
		eff_h = (geom.height == '0) ? ROW_BITS'(1) : geom.height;
	end

	assign pixels.ready = ((QCNT_BITS+1)'(queue_count) + (QCNT_BITS+1)'(valid_s1))
		< (QCNT_BITS+1)'(QUEUE_DEPTH);

	always_comb begin
		accept      = pixels.valid && pixels.ready;
		is_drain    = (pixels.kind == KIND_DRAIN);
		take_pix    = accept && !is_drain && (in_row_q < eff_h);
		take_drain  = accept && is_drain && (in_row_q >= eff_h);
		take        = take_pix || take_drain;
		in_col_inc  = COLX_BITS'(in_col_q) + COLX_BITS'(1);
		out_col_inc = COLX_BITS'(out_col_q) + COLX_BITS'(1);
		vic_x       = (out_col_inc >= eff_w_x) ? '0 : out_col_inc;
		out_row_x   = ROWX_BITS'(out_row_q);
		eff_h_x     = ROWX_BITS'(eff_h);

		if (is_drain) begin
			rd_addr   = vic_x[COL_BITS-1:0];
			gate      = 1'b1;
			row_start = (vic_x == '0);
			h1_load   = (eff_h == ROW_BITS'(1)) && (out_row_q == '0) && (out_col_q == '0);
		end else begin
			rd_addr   = in_col_q;
			gate      = (in_row_q >= ROW_BITS'(2))
				|| ((in_row_q == ROW_BITS'(1)) && (in_col_q != '0));
			row_start = (in_col_q == '0);
			h1_load   = 1'b0;
		end

		// tap masks: zero padding above, below, left and right of the image
		rmask[0] = (out_row_q != '0);
		rmask[1] = (out_row_x + ROWX_BITS'(1)) <= eff_h_x;
		rmask[2] = (out_row_x + ROWX_BITS'(2)) <= eff_h_x;
		cmask[0] = (out_col_q != '0);
		cmask[1] = out_col_inc <= eff_w_x;
		cmask[2] = (out_col_inc + COLX_BITS'(1)) <= eff_w_x;

		frame_last = ((out_row_x + ROWX_BITS'(1)) == eff_h_x) && (out_col_inc == eff_w_x);
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (geom.restart) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (take) begin
			if (gate && frame_last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (take_pix) begin
					if (in_col_inc >= eff_w_x) begin
						in_col_q <= '0;
						in_row_q <= in_row_q + ROW_BITS'(1);
					end else begin
						in_col_q <= in_col_inc[COL_BITS-1:0];
					end
				end
				if (gate) begin
					if (out_col_inc >= eff_w_x) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + ROW_BITS'(1);
					end else begin
						out_col_q <= out_col_inc[COL_BITS-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			addr_s1       <= rd_addr;
			pix_s1        <= !is_drain;
			pixel_s1      <= is_drain ? '0 : pixels.pixel;
			gate_s1       <= gate;
			row_start_s1  <= row_start;
			frame_last_s1 <= frame_last;
			h1_load_s1    <= h1_load;
			rmask_s1      <= rmask;
			cmask_s1      <= cmask;
			// forward the write landing on the address being read this cycle
			byp_s1        <= wr_en && (addr_s1 == rd_addr);
			byp_data_s1   <= wr_data;
		end
	end

	c2d_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (wr_data),
		.re    (take),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// entry layout: upper row in the high byte, lower row in the low byte
	assign entry   = byp_s1 ? byp_data_s1 : ram_rdata;
	assign wr_en   = valid_s1 && pix_s1;
	assign wr_data = {entry[PIXEL_BITS-1:0], pixel_s1};

	// copy of line entry zero for the single-row drain
	always_ff @(posedge clk) begin
		if (wr_en && (addr_s1 == '0)) begin
			shadow_q <= wr_data;
		end
	end

	always_comb begin
		push                 = valid_s1;
		push_word.col[0]     = entry[ENTRY_BITS-1:PIXEL_BITS];
		push_word.col[1]     = entry[PIXEL_BITS-1:0];
		push_word.col[2]     = pixel_s1;
		push_word.spec[0]    = shadow_q[ENTRY_BITS-1:PIXEL_BITS];
		push_word.spec[1]    = shadow_q[PIXEL_BITS-1:0];
		push_word.spec[2]    = '0;
		push_word.gate       = gate_s1;
		push_word.row_start  = row_start_s1;
		push_word.frame_last = frame_last_s1;
		push_word.h1_load    = h1_load_s1;
		push_word.rmask      = rmask_s1;
		push_word.cmask      = cmask_s1;
	end

	a_in_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_row_q <= eff_h)
		else $error("input row ran past the image height");

	a_out_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		COLX_BITS'(out_col_q) < eff_w_x)
		else $error("output column ran past the image width");

	a_out_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_row_q < eff_h)
		else $error("output row ran past the image height");
endmodule

// File: hw/rtl/c2d_queue.sv
// Short queue of classified column words between front and back.
// Depends on c2d_pkg.
module c2d_queue import c2d_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  col_word_t            push_word,
	input  logic                 pop,
	output col_word_t            head,
	output logic [QCNT_BITS-1:0] count
);
	col_word_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + QPTR_BITS'(1);
			end
			count_q <= count_q + QCNT_BITS'(push) - QCNT_BITS'(pop);
		end
	end

	assign head  = slots_q[rd_ptr_q];
	assign count = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < QCNT_BITS'(QUEUE_DEPTH)))
		else $error("column queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("column queue popped while empty");
endmodule

// File: hw/rtl/c2d_back.sv
// Back end: window registers, nine-tap multiply, adder tree, shift and output register.
// Depends on c2d_pkg and c2d_stream_if; drains c2d_queue.
module c2d_back import c2d_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  arith_cfg_t           acfg,
	input  col_word_t            head,
	input  logic [QCNT_BITS-1:0] queue_count,
	output logic                 pop,
	c2d_out_if.source            results
);
	column_t                    win0_q, win1_q, w1_eff, c2;
	column_t                    cols [KERNEL_SIZE];
	logic signed [PROD_BITS-1:0] prod_c  [KERNEL_SIZE][KERNEL_SIZE];
	logic signed [PROD_BITS-1:0] prod_s1 [KERNEL_SIZE][KERNEL_SIZE];
	logic signed [SUM_BITS-1:0]  rsum_c  [KERNEL_SIZE];
	logic signed [SUM_BITS-1:0]  rsum_s2 [KERNEL_SIZE];
	logic signed [SUM_BITS-1:0]  total;
	logic                        valid_s1, valid_s2, out_valid_q;
	logic                        fl_s1, fl_s2, out_fl_q;
	logic signed [OUT_BITS-1:0]  out_pixel_q;
	logic                        head_valid, adv1, adv2, adv_out;

	assign adv_out    = !out_valid_q || results.ready;
	assign adv2       = !valid_s2 || adv_out;
	assign adv1       = !valid_s1 || adv2;
	assign head_valid = (queue_count != '0);
	assign pop        = head_valid && adv1;

	always_comb begin
		w1_eff  = head.h1_load ? head.spec : win1_q;
		c2      = head.row_start ? '0 : head.col;
		cols[0] = win0_q;
		cols[1] = w1_eff;
		cols[2] = c2;
	end

	// tap (dy, dx) meets the kernel coefficient mirrored in both axes
	for (genvar dy = 0; dy < KERNEL_SIZE; dy++) begin : g_row
		for (genvar dx = 0; dx < KERNEL_SIZE; dx++) begin : g_col
			logic signed [COEF_BITS-1:0] coef;
			logic signed [PROD_BITS-1:0] prod;
			assign coef = $signed(acfg.krows[KERNEL_SIZE-1-dy]
				[COEF_BITS*(KERNEL_SIZE-1-dx) +: COEF_BITS]);
			assign prod = $signed({1'b0, cols[dx][dy]}) * coef;
			assign prod_c[dy][dx] = (head.rmask[dy] && head.cmask[dx]) ? prod : '0;
		end
	end

	// window: shift in the new column, clear after the last pixel of a frame or on a size write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win0_q <= '0;
			win1_q <= '0;
		end else if (acfg.restart) begin
			win0_q <= '0;
			win1_q <= '0;
		end else if (pop) begin
			if (head.gate && head.frame_last) begin
				win0_q <= '0;
				win1_q <= '0;
			end else begin
				if (!head.row_start) begin
					win0_q <= w1_eff;
				end
				win1_q <= head.col;
			end
		end
	end

	always_comb begin
		for (int r = 0; r < KERNEL_SIZE; r++) begin
			rsum_c[r] = '0;
			for (int c = 0; c < KERNEL_SIZE; c++) begin
				rsum_c[r] = rsum_c[r] + SUM_BITS'(prod_s1[r][c]);
			end
		end
		total = '0;
		for (int r = 0; r < KERNEL_SIZE; r++) begin
			total = total + rsum_s2[r];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= pop && head.gate;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			prod_s1 <= prod_c;
			fl_s1   <= head.frame_last;
		end
		if (adv2) begin
			rsum_s2 <= rsum_c;
			fl_s2   <= fl_s1;
		end
		if (adv_out) begin
			out_pixel_q <= OUT_BITS'(total >>> acfg.shift);
			out_fl_q    <= fl_s2;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.out_pixel  = out_pixel_q;
	assign results.frame_last = out_fl_q;
endmodule

// File: test/c2d_conv_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the 3x3 zero-padded convolution core: mirrors line stores, window,
// counters and registers, and compares each result word with the predicted one.
// Depends on c2d_pkg and the stream interfaces of c2d_stream_if.
module c2d_conv_checker import c2d_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	c2d_in_if                         pixels,
	c2d_out_if                        results,
	output int                        pending,
	output int                        errors
);

	typedef struct packed {
		logic signed [OUT_BITS-1:0] value;
		logic                       last;
	} out_word_t;

	out_word_t due_pixels [$];
	out_word_t head;

	logic [PIXEL_BITS-1:0] line_upper [MAX_WIDTH];
	logic [PIXEL_BITS-1:0] line_lower [MAX_WIDTH];
	column_t               win_left;
	column_t               win_mid;
	int unsigned           in_col, in_row, out_col, out_row;

	logic [KROW_BITS-1:0]  krows [KERNEL_SIZE];
	logic [WIDTH_BITS-1:0] img_width;
	logic [ROW_BITS-1:0]   img_height;
	logic [SHIFT_BITS-1:0] rshift;

	function automatic int unsigned act_width();
		if (img_width == 0)
			return 1;
		if (img_width > MAX_WIDTH)
			return MAX_WIDTH;
		return img_width;
	endfunction

	function automatic int unsigned act_height();
		return (img_height == 0) ? 1 : img_height;
	endfunction

	function automatic void restart_frame();
		in_col   = 0;
		in_row   = 0;
		out_col  = 0;
		out_row  = 0;
		win_left = '0;
		win_mid  = '0;
	endfunction

	// Emit the sum at the output position (if gated), shift the window, advance.
	function automatic void slide_window(column_t fresh, bit row_start, bit gate);
		int unsigned w, h, dy, dx;
		int          acc;
		column_t     taps [3];
		out_word_t   word;
		w = act_width();
		h = act_height();
		if (gate) begin
			taps[0] = win_left;
			taps[1] = win_mid;
			taps[2] = row_start ? '0 : fresh;
			acc = 0;
			for (dy = 0; dy < 3; dy++) begin
				if (out_row + dy < 1 || out_row + dy > h)
					continue;
				for (dx = 0; dx < 3; dx++) begin
					if (out_col + dx < 1 || out_col + dx > w)
						continue;
					// flipped kernel
					acc += int'(taps[dx][dy]) *
						int'($signed(krows[2 - dy][COEF_BITS * (2 - dx) +: COEF_BITS]));
				end
			end
			acc = acc >>> rshift;
			word.value = acc[OUT_BITS-1:0];
			word.last  = (out_row + 1 == h) && (out_col + 1 == w);
			due_pixels.push_back(word);
		end
		if (!row_start)
			win_left = win_mid;
		win_mid = fresh;
		if (gate) begin
			if (word.last) begin
				restart_frame();
			end else begin
				out_col++;
				if (out_col >= w) begin
					out_col = 0;
					out_row++;
				end
			end
		end
	endfunction

	function automatic void convolve_word(kind_t kind_in, logic [PIXEL_BITS-1:0] px);
		int unsigned w, h, ic, vic;
		column_t     col;
		bit          gate;
		w = act_width();
		h = act_height();
		if (kind_in == KIND_PIXEL) begin
			if (in_row >= h)
				return;
			ic = (in_col >= MAX_WIDTH) ? 0 : in_col;
			col[0] = line_upper[ic];
			col[1] = line_lower[ic];
			col[2] = px;
			line_upper[ic] = col[1];
			line_lower[ic] = col[2];
			gate = (in_row >= 2) || (in_row == 1 && ic >= 1);
			in_col = ic + 1;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
			slide_window(col, ic == 0, gate);
		end else begin
			if (in_row < h)
				return;
			// single-row image: the middle column is loaded from the stores
			if (h == 1 && out_row == 0 && out_col == 0) begin
				win_mid[0] = line_upper[0];
				win_mid[1] = line_lower[0];
				win_mid[2] = '0;
			end
			vic = out_col + 1;
			if (vic >= w || vic >= MAX_WIDTH)
				vic = 0;
			col[0] = line_upper[vic];
			col[1] = line_lower[vic];
			col[2] = '0;
			slide_window(col, vic == 0, 1'b1);
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			krows[0]   = KROW_TOP_RST;
			krows[1]   = KROW_MID_RST;
			krows[2]   = KROW_BOT_RST;
			img_width  = WIDTH_RST;
			img_height = HEIGHT_RST;
			rshift     = SHIFT_RST;
			foreach (line_upper[i]) begin
				line_upper[i] = '0;
				line_lower[i] = '0;
			end
			restart_frame();
			due_pixels.delete();
			errors = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_KERNEL_TOP:   krows[0] = cfg_data;
					REG_KERNEL_MID:   krows[1] = cfg_data;
					REG_KERNEL_BOT:   krows[2] = cfg_data;
					REG_IMAGE_WIDTH: begin
						img_width = cfg_data[WIDTH_BITS-1:0];
						restart_frame();
					end
					REG_IMAGE_HEIGHT: begin
						img_height = cfg_data[ROW_BITS-1:0];
						restart_frame();
					end
					REG_RESULT_SHIFT: rshift = cfg_data[SHIFT_BITS-1:0];
					default: ;
				endcase
			end
			if (pixels.valid && pixels.ready)
				convolve_word(kind_t'(pixels.kind), pixels.pixel);
			if (results.valid && results.ready) begin
				if (due_pixels.size() == 0) begin
					if (errors < 10)
						$display("%0t: unexpected result %0d last %0b", $realtime,
							results.out_pixel, results.frame_last);
					errors++;
				end else begin
					head = due_pixels.pop_front();
					if (results.out_pixel !== head.value || results.frame_last !== head.last) begin
						if (errors < 10)
							$display("%0t: result mismatch: expected %0d last %0b, got %0d last %0b",
								$realtime, head.value, head.last,
								results.out_pixel, results.frame_last);
						errors++;
					end
				end
			end
		end
		pending = due_pixels.size();
	end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// Top of the convolution core testbench: clock, reset, register set-up, pixel and
// drain stimulus, result back-pressure and the verdict.
// Depends on c2d_pkg, c2d_stream_if, conv2d_same_zero_pad_core and c2d_conv_checker.
module tb;
	import c2d_pkg::*;

	localparam int HALF_PERIOD   = 2;        // 4 ns clock
	localparam int RESET_CYCLES  = 5;
	localparam int SETTLE_CYCLES = 16;       // covers the pipeline depth plus margin
	localparam int HOLD_CYCLES   = 300;
	localparam int IDLE_PCT      = 28;
	localparam int RANDOM_WORDS  = 1250;
	localparam int NOISE_PCT     = 5;
	localparam int TIMEOUT_NS    = 2_000_000;

	// 3x3 directed image: both extremes, a mid value and single-bit patterns
	localparam logic [8:0][PIXEL_BITS-1:0] FRAME_A = {
		8'hFF, 8'h00, 8'hFF,
		8'h01, 8'h80, 8'hFE,
		8'h7F, 8'hFF, 8'h00
	};

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_write;
	reg_index_t                cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	c2d_in_if  pix ();
	c2d_out_if res ();

	int          pending;
	int          errors;
	bit          src_idle_en  = 1'b1;
	bit          sink_idle_en = 1'b1;
	bit          hold_req     = 1'b0;
	int unsigned frame_w, frame_h;      // effective sizes of the current image
	int unsigned word_count;            // words that reach the convolution

	conv2d_same_zero_pad_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixels    (pix),
		.results   (res)
	);

	c2d_conv_checker conv_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixels    (pix),
		.results   (res),
		.pending   (pending),
		.errors    (errors)
	);

	initial begin
		clk = 1'b0;
		forever #(HALF_PERIOD) clk = ~clk;
	end

	// Pixel values lean on the extremes so the sums hit their limits.
	function automatic logic [PIXEL_BITS-1:0] pick_pixel();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return PIXEL_BITS'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [KROW_BITS-1:0] pick_krow();
		case ($urandom_range(7))
			0: return {KERNEL_SIZE{8'h80}};
			1: return {KERNEL_SIZE{8'h7F}};
			default: return KROW_BITS'($urandom());
		endcase
	endfunction

	// Offer one word from a falling edge and hold it until taken; return on the
	// falling edge after the accepting one, leaving valid high for the next word.
	task automatic send_word(kind_t k, logic [PIXEL_BITS-1:0] p);
		while (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
			pix.valid <= 1'b0;
			@(negedge clk);
		end
		pix.valid <= 1'b1;
		pix.kind  <= k;
		pix.pixel <= p;
		@(posedge clk);
		while (!pix.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drop valid, wait for every predicted result, then let the pipeline empty
	// of words that produced nothing.
	task automatic settle();
		pix.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write all six registers on consecutive edges; the size writes restart the image.
	task automatic setup(input logic [WIDTH_BITS-1:0] w, input logic [ROW_BITS-1:0] h,
			input logic [KROW_BITS-1:0] kt, km, kb, input logic [SHIFT_BITS-1:0] sh);
		settle();
		frame_w = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
		frame_h = (h == 0) ? 1 : h;
		cfg_write <= 1'b1;
		cfg_index <= REG_KERNEL_TOP;
		cfg_data  <= kt;
		@(negedge clk);
		cfg_index <= REG_KERNEL_MID;
		cfg_data  <= km;
		@(negedge clk);
		cfg_index <= REG_KERNEL_BOT;
		cfg_data  <= kb;
		@(negedge clk);
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data  <= CFG_DATA_BITS'(w);
		@(negedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data  <= CFG_DATA_BITS'(h);
		@(negedge clk);
		cfg_index <= REG_RESULT_SHIFT;
		cfg_data  <= CFG_DATA_BITS'(sh);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// Stream npix random pixels; a complete image is followed by the drain ticks
	// that release its lagging outputs. Noise words are ignored by the block:
	// drains slipped in among the pixels, pixels among the drains (never after
	// the last drain, which would open the next image).
	task automatic run_frame(int unsigned npix, int unsigned noise_pct);
		int unsigned tail, i;
		tail = (frame_h == 1) ? frame_w : frame_w + 1;
		for (i = 0; i < npix; i++) begin
			if ($urandom_range(99) < noise_pct)
				send_word(KIND_DRAIN, pick_pixel());
			send_word(KIND_PIXEL, pick_pixel());
		end
		word_count += npix;
		if (npix != frame_w * frame_h)
			return;
		for (i = 0; i < tail; i++) begin
			if ($urandom_range(99) < noise_pct)
				send_word(KIND_PIXEL, pick_pixel());
			send_word(KIND_DRAIN, pick_pixel());
		end
		word_count += tail;
	endtask

	// Result side: random stalls, or a long hold-off when asked, counted here.
	initial begin : result_sink
		int unsigned hold_left;
		hold_left = 0;
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= !(sink_idle_en && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	initial begin : stimulus
		logic [WIDTH_BITS-1:0] w;
		logic [ROW_BITS-1:0]   h;
		int unsigned           frame_no, i;
		bit                    broken;

		arst_n    = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_KERNEL_TOP;
		cfg_data  = '0;
		pix.valid = 1'b0;
		pix.kind  = KIND_PIXEL;
		pix.pixel = '0;
		word_count = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: 3x3 image with an asymmetric kernel, so a missed flip shows.
		// An early drain is dropped, and so is a pixel sent while outputs are
		// still pending after the last row.
		setup(3, 3, 24'h7F0380, 24'h02FF05, 24'h8110F0, 0);
		send_word(KIND_DRAIN, 8'hA5);
		for (i = 0; i < 9; i++)
			send_word(KIND_PIXEL, FRAME_A[8 - i]);
		send_word(KIND_DRAIN, 8'h00);
		send_word(KIND_PIXEL, 8'h55);
		repeat (3) send_word(KIND_DRAIN, 8'hFF);

		// Zero width and height act as 1x1; the most negative kernel and the
		// widest shift round a negative sum towards minus infinity.
		setup(0, 0, 24'h808080, 24'h808080, 24'h808080, 15);
		send_word(KIND_PIXEL, 8'hFF);
		send_word(KIND_DRAIN, 8'h00);

		// Tallest height: only the start of the image, abandoned by the next set-up.
		setup(4, 16'hFFFF, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 4);
		for (i = 0; i < 8; i++)
			send_word(KIND_PIXEL, 8'hFF);

		// Back-pressure: hold the results off while a whole image is offered,
		// so the column queue fills and the input stalls.
		setup(16, 6, pick_krow(), pick_krow(), pick_krow(), 3);
		hold_req = 1'b1;
		run_frame(16 * 6, 0);

		// Random images, mostly small and complete, some cut short. Frames often
		// run back to back with no set-up, through the end-of-frame restart.
		frame_no = 0;
		broken   = 1'b1;
		while (word_count < RANDOM_WORDS) begin
			src_idle_en  = !(frame_no >= 8 && frame_no < 16);
			sink_idle_en = src_idle_en;
			if (broken || $urandom_range(99) < 60) begin
				case ($urandom_range(19))
					0:       w = 0;
					1:       w = 1;
					2, 3:    w = WIDTH_BITS'($urandom_range(9, 40));
					default: w = WIDTH_BITS'($urandom_range(2, 8));
				endcase
				case ($urandom_range(9))
					0:       h = 0;
					1:       h = 1;
					default: h = ROW_BITS'($urandom_range(2, 6));
				endcase
				setup(w, h, pick_krow(), pick_krow(), pick_krow(),
					($urandom_range(3) == 0) ? 4'd0 : SHIFT_BITS'($urandom_range(15)));
			end
			broken = ($urandom_range(99) < 12);
			if (broken)
				run_frame($urandom_range(frame_w * frame_h - 1), NOISE_PCT);
			else
				run_frame(frame_w * frame_h, NOISE_PCT);
			frame_no++;
		end
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;

		settle();
		if (errors == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/c2d_pkg.sv
hw/rtl/c2d_stream_if.sv
hw/rtl/c2d_ram.sv
hw/rtl/c2d_front.sv
hw/rtl/c2d_queue.sv
hw/rtl/c2d_back.sv
hw/rtl/conv2d_same_zero_pad_core.sv
test/c2d_conv_checker.sv
test/tb.sv
